>>> hw/rtl/wvb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wvb_pkg - shared constants for the running variance bank
// Sizes of the measure bank, word widths and stream packing.
// ----------------------------------------------------------------------------
package wvb_pkg;

  // bank size, 1 to 16 with a 4-bit measure field
  localparam int unsigned NumMeasures = 16;
  localparam int unsigned MeasW       = 4;
  localparam int unsigned MeasSelW    = (NumMeasures > 1) ? $clog2(NumMeasures) : 1;

  localparam int unsigned WordW = 32;
  localparam int unsigned SumW  = 64;

  // serial divider: one quotient bit per cycle
  localparam int unsigned DivSteps = WordW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // stream packing
  localparam int unsigned InDataW   = ((MeasW + WordW + 7) / 8) * 8;
  localparam int unsigned InUserW   = 2;
  localparam int unsigned OutDataW  = ((MeasW + WordW + SumW + WordW + 7) / 8) * 8;
  localparam int unsigned OutUserW  = 2;

endpackage : wvb_pkg
`default_nettype wire

>>> hw/rtl/wvb_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wvb_divider - serial unsigned restoring divider
// One quotient bit per cycle; done_o pulses when the quotient is complete.
// ----------------------------------------------------------------------------
module wvb_divider (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [wvb_pkg::WordW-1:0] dividend_i,
  input  wire logic [wvb_pkg::WordW-1:0] divisor_i,
  output logic                           done_o,
  output logic [wvb_pkg::WordW-1:0]      quotient_o
);
  import wvb_pkg::*;

  localparam logic [DivCntW-1:0] LastStep = DivCntW'(DivSteps - 1);

  logic               busy_q, done_q;
  logic [DivCntW-1:0] step_q;
  logic [WordW-1:0]   rem_q, quo_q, dsr_q;
  logic [WordW:0]     trial;
  logic [WordW:0]     diff;
  logic               fits;

  // shift the next dividend bit into the remainder, subtract if it fits
  assign trial = {rem_q, quo_q[WordW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = !diff[WordW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dsr_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q  <= fits ? diff[WordW-1:0] : trial[WordW-1:0];
        quo_q  <= {quo_q[WordW-2:0], fits};
        step_q <= step_q + DivCntW'(1);
        if (step_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule : wvb_divider
`default_nettype wire

>>> hw/rtl/welford_running_variance_bank_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// welford_running_variance_bank_top - bank of Welford mean/variance accumulators
// Per-measure running mean (Q16.16), saturating sum of squared deviations
// (Q32.32) and sample count, updated one sample transaction at a time.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)                         | tuser (low bit up)
//  ---------+-----+--------------------------------------------+---------------------------
//  s_axis   | in  | measure[3:0], sample_value[35:4]           | req_type[0], sample_ok[1]
//  m_axis   | out | measure_out[3:0], mean_out[35:4],          | measure_live[0],
//           |     | sq_sum_out[99:36], count_out[131:100]      | any_live[1]
//
//  A sample that updates its measure goes through the 32-step serial divide
//  by the new count, which dominates, and then through three passes of one
//  32x32 multiplier before the next input transaction is taken.
//  Restart, dead-measure, invalid-sample and saturated-count items skip both.
//  After reset every measure is live and reads as zero.
//  A result waits in the output register while the next item is taken;
//  a stalled m_axis only holds the sequencer in its output step.
// ----------------------------------------------------------------------------
module welford_running_variance_bank_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // slave side
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire logic [wvb_pkg::InDataW-1:0]  s_axis_tdata_i,  // measure, sample_value
  input  wire logic [wvb_pkg::InUserW-1:0]  s_axis_tuser_i,  // req_type, sample_ok
  // master side
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  output logic [wvb_pkg::OutDataW-1:0]      m_axis_tdata_o,  // measure_out, mean_out,
                                                              // sq_sum_out, count_out
  output logic [wvb_pkg::OutUserW-1:0]      m_axis_tuser_o   // measure_live, any_live
);
  import wvb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_DIV,
    ST_MUL_DQ,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_TERM,
    ST_WB,
    ST_OUT
  } state_e;

  state_e state_q;

  // accepted transaction
  logic             req_q, ok_q;
  logic [MeasW-1:0] idx_q;
  logic [WordW-1:0] val_q;

  // working copy of the entry; also carries the result
  logic [WordW-1:0] mean_r_q, cnt_r_q;
  logic [SumW-1:0]  sum_r_q;
  logic             res_live_q;

  // datapath
  logic             dneg_q;
  logic [WordW-1:0] absd_q;
  logic [SumW-1:0]  prod_q, hm_q, term_q;

  // per-measure state; vld_q marks entries written since the last restart
  logic [NumMeasures-1:0] live_q, vld_q;
  logic [WordW-1:0]       mean_q [NumMeasures];
  logic [SumW-1:0]        sum_q  [NumMeasures];
  logic [WordW-1:0]       cnt_q  [NumMeasures];

  // output register
  logic             m_valid_q;
  logic [MeasW-1:0] o_meas_q;
  logic [WordW-1:0] o_mean_q, o_cnt_q;
  logic [SumW-1:0]  o_sum_q;
  logic             o_live_q, o_any_q;

  logic s_hs;
  logic out_load;
  assign s_hs = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  // output register takes a new result when empty or draining this cycle
  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready_i);

  // ---------------------------------------------------------------- entry read
  logic [MeasSelW-1:0] sel;
  logic                in_range, ent_vld;
  logic [WordW-1:0]    rd_mean, rd_cnt;
  logic [SumW-1:0]     rd_sum;

  assign sel      = MeasSelW'(idx_q);
  assign in_range = (32'(idx_q) < 32'(NumMeasures));
  assign ent_vld  = vld_q[sel];
  assign rd_mean  = ent_vld ? mean_q[sel] : '0;
  assign rd_sum   = ent_vld ? sum_q[sel]  : '0;
  assign rd_cnt   = ent_vld ? cnt_q[sel]  : '0;

  // d = value - mean, exact in 33 bits; |d| always fits 32
  logic [WordW:0]   d33, dneg33;
  logic [WordW-1:0] absd_c;
  assign d33    = {val_q[WordW-1], val_q} - {rd_mean[WordW-1], rd_mean};
  assign dneg33 = -d33;
  assign absd_c = d33[WordW] ? dneg33[WordW-1:0] : d33[WordW-1:0];

  logic do_update;
  assign do_update = (state_q == ST_RD) && !req_q && in_range && live_q[sel] &&
                     ok_q && (rd_cnt != '1);

  // --------------------------------------------------------------- divider
  logic             div_done;
  logic [WordW-1:0] div_quo;

  wvb_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (do_update),
    .dividend_i (absd_c),
    .divisor_i  (rd_cnt + 32'd1),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // ------------------------------------------------- shared 32x32 multiplier
  // dq: |d|*|q|; hi/lo: halves of that product times (n - 1)
  logic [WordW-1:0] mul_a, mul_b;
  logic [SumW-1:0]  mul_p;

  always_comb begin
    case (state_q)
      ST_MUL_HI: mul_a = prod_q[SumW-1:WordW];
      ST_MUL_LO: mul_a = prod_q[WordW-1:0];
      default:   mul_a = absd_q;
    endcase
  end
  assign mul_b = (state_q == ST_MUL_DQ) ? div_quo : cnt_r_q;
  assign mul_p = SumW'(mul_a) * SumW'(mul_b);

  // saturating term: (hi*m << 32) + lo*m
  logic [SumW:0] t65;
  assign t65 = {1'b0, hm_q[WordW-1:0], {WordW{1'b0}}} + {1'b0, prod_q};

  // write-back values
  logic [SumW:0]    sum65;
  logic [SumW-1:0]  new_sum;
  logic [WordW:0]   q33;
  logic [WordW+1:0] nm34;
  logic [WordW-1:0] new_mean, new_cnt;

  assign sum65   = {1'b0, sum_r_q} + {1'b0, term_q};
  assign new_sum = sum65[SumW] ? '1 : sum65[SumW-1:0];
  assign q33     = dneg_q ? -{1'b0, div_quo} : {1'b0, div_quo};
  assign nm34    = {{2{mean_r_q[WordW-1]}}, mean_r_q} + {q33[WordW], q33};
  assign new_cnt = cnt_r_q + 32'd1;

  always_comb begin
    if (nm34[WordW+1] != nm34[WordW] || nm34[WordW] != nm34[WordW-1]) begin
      new_mean = nm34[WordW+1] ? {1'b1, {(WordW-1){1'b0}}} : {1'b0, {(WordW-1){1'b1}}};
    end else begin
      new_mean = nm34[WordW-1:0];
    end
  end

  // ------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      req_q      <= 1'b0;
      ok_q       <= 1'b0;
      idx_q      <= '0;
      val_q      <= '0;
      mean_r_q   <= '0;
      sum_r_q    <= '0;
      cnt_r_q    <= '0;
      res_live_q <= 1'b0;
      dneg_q     <= 1'b0;
      absd_q     <= '0;
      prod_q     <= '0;
      hm_q       <= '0;
      term_q     <= '0;
      live_q     <= '1;
      vld_q      <= '0;
      m_valid_q  <= 1'b0;
      o_meas_q   <= '0;
      o_mean_q   <= '0;
      o_sum_q    <= '0;
      o_cnt_q    <= '0;
      o_live_q   <= 1'b0;
      o_any_q    <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready_i && !out_load) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_hs) begin
            req_q   <= s_axis_tuser_i[0];
            ok_q    <= s_axis_tuser_i[1];
            idx_q   <= s_axis_tdata_i[MeasW-1:0];
            val_q   <= s_axis_tdata_i[MeasW+WordW-1:MeasW];
            state_q <= ST_RD;
          end
        end

        ST_RD: begin
          if (req_q) begin
            // restart: all entries read as zero, all measures live
            live_q     <= '1;
            vld_q      <= '0;
            idx_q      <= '0;
            mean_r_q   <= '0;
            sum_r_q    <= '0;
            cnt_r_q    <= '0;
            res_live_q <= 1'b1;
            state_q    <= ST_OUT;
          end else if (!in_range) begin
            mean_r_q   <= '0;
            sum_r_q    <= '0;
            cnt_r_q    <= '0;
            res_live_q <= 1'b0;
            state_q    <= ST_OUT;
          end else begin
            mean_r_q <= rd_mean;
            sum_r_q  <= rd_sum;
            cnt_r_q  <= rd_cnt;
            dneg_q   <= d33[WordW];
            absd_q   <= absd_c;
            if (do_update) begin
              res_live_q <= 1'b1;
              state_q    <= ST_DIV;
            end else begin
              // invalid sample kills a live measure until the next restart
              if (live_q[sel] && !ok_q) begin
                live_q[sel] <= 1'b0;
                res_live_q  <= 1'b0;
              end else begin
                res_live_q  <= live_q[sel];
              end
              state_q <= ST_OUT;
            end
          end
        end

        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_MUL_DQ;
          end
        end

        ST_MUL_DQ: begin
          prod_q  <= mul_p;
          state_q <= ST_MUL_HI;
        end

        ST_MUL_HI: begin
          hm_q    <= mul_p;
          state_q <= ST_MUL_LO;
        end

        ST_MUL_LO: begin
          prod_q  <= mul_p;
          state_q <= ST_TERM;
        end

        ST_TERM: begin
          term_q  <= (|hm_q[SumW-1:WordW] || t65[SumW]) ? '1 : t65[SumW-1:0];
          state_q <= ST_WB;
        end

        ST_WB: begin
          mean_r_q   <= new_mean;
          sum_r_q    <= new_sum;
          cnt_r_q    <= new_cnt;
          vld_q[sel] <= 1'b1;
          state_q    <= ST_OUT;
        end

        ST_OUT: begin
          if (out_load) begin
            m_valid_q <= 1'b1;
            o_meas_q  <= idx_q;
            o_mean_q  <= mean_r_q;
            o_sum_q   <= sum_r_q;
            o_cnt_q   <= cnt_r_q;
            o_live_q  <= res_live_q;
            o_any_q   <= |live_q;
            state_q   <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // entry storage, written once per completed update
  always_ff @(posedge clk_i) begin
    if (state_q == ST_WB) begin
      mean_q[sel] <= new_mean;
      sum_q[sel]  <= new_sum;
      cnt_q[sel]  <= new_cnt;
    end
  end

  // ---------------------------------------------------------------- outputs
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - MeasW - 2*WordW - SumW){1'b0}},
                            o_cnt_q, o_sum_q, o_mean_q, o_meas_q};
  assign m_axis_tuser_o  = {o_any_q, o_live_q};

  // ------------------------------------------------------------- assertions
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide step");

  a_restart_all_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD && req_q) |=> (live_q == '1 && vld_q == '0))
    else $error("restart did not revive and clear the bank");

  a_wb_live_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WB) |-> (live_q[sel] && res_live_q))
    else $error("update written back for a dead measure");

  a_ready_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && (!m_valid_q || m_axis_tready_i)) |=> m_valid_q)
    else $error("result lost at the output register");

endmodule : welford_running_variance_bank_top
`default_nettype wire
